### hw/rtl/fdmd_pkg.sv
// Shared constants, types and helpers for the frame difference motion detector.
// No dependencies; imported by the top level, fdmd_act and fdmd_track.
`default_nettype none
package fdmd_pkg;

  localparam int FRAMES     = 4;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W  = 8;
  localparam int SLOT_W = (FRAMES > 2) ? $clog2(FRAMES) : 1;
  localparam int ROW_W  = FRAMES * PIX_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  localparam int X_W   = 8;
  localparam int Y_W   = 8;
  localparam int DIM_W = 9;
  localparam int THR_W = 10;
  localparam int ACT_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  // activity = 3 * sum / FRAMES through an exact reciprocal multiply
  localparam int SUM_W   = $clog2((FRAMES - 1) * 255 + 1);
  localparam int SUM3_W  = $clog2(3 * (FRAMES - 1) * 255 + 1);
  localparam int DIV_L   = $clog2(FRAMES);
  localparam int DIV_S   = SUM3_W + DIV_L;
  localparam int RECIP   = ((2 ** DIV_S) + FRAMES - 1) / FRAMES;
  localparam int RECIP_W = SUM3_W + 1;
  localparam int PROD_W  = SUM3_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_DETECT_THR   = 3'd2,
    CFG_PAINT_THR    = 3'd3,
    CFG_PAINT_EN     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE,
    ST_ADD,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic merge;
    logic add;
    logic mul;
  } act_ctl_t;

  // x / 3 for 8-bit x: (x * 171) >> 9 is exact below 512
  function automatic logic [PIX_W-1:0] div3(input logic [PIX_W-1:0] v);
    logic [PIX_W+8:0] p;
    p = {9'd0, v} * (PIX_W + 9)'(171);
    return p[PIX_W+8:9];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/frame_difference_motion_detector.sv
// Top level of the frame difference motion detector: configuration, sequencer,
// frame store RAM. Depends on fdmd_pkg, fdmd_ram, fdmd_act, fdmd_track.
//
// channel  direction  handshake             payload
// in_      slave      in_tvalid/in_tready   tdata: red, green, blue
// out_     master     out_tvalid/out_tready tdata: activity..box, tlast: frame_done
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Each pixel goes through accept and row read, merge and write back, sum, divide and result
// load in turn; the serial merge, sum and divide stages let a new pixel in only after that load.
// After reset a clearing pass writes zeros to all 65536 rows, one per cycle;
// pixels are not accepted during it, configuration writes are.
// A stalled result holds in the output register; the next pixel still enters.
`default_nettype none
module frame_difference_motion_detector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic [fdmd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [9:0] activity, [10] paint_mark, [11] detect_mark, [19:12] pixel_x,
  // [27:20] pixel_y, [28] motion_found, [37:29] box_min_x, [45:38] box_max_x,
  // [54:46] box_min_y, [62:55] box_max_y, [63] zero
  output logic      [fdmd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdmd_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [DIM_W-1:0]  fw_r, fh_r, w_eff, h_eff;
  logic [THR_W-1:0]  det_thr_r, paint_thr_r;
  logic              paint_en_r;
  act_ctl_t          ctl;
  logic              accept, fin, room;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ROW_W-1:0]  wdata, merged, rdata;
  logic [ACT_W-1:0]  act;
  logic [X_W-1:0]    col;
  logic [Y_W-1:0]    row;
  logic [SLOT_W-1:0] slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= DIM_W'(MAX_WIDTH);
      fh_r        <= DIM_W'(MAX_HEIGHT);
      det_thr_r   <= '0;
      paint_thr_r <= '0;
      paint_en_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r        <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_r        <= cfg_data[DIM_W-1:0];
        CFG_DETECT_THR:   det_thr_r   <= cfg_data[THR_W-1:0];
        CFG_PAINT_THR:    paint_thr_r <= cfg_data[THR_W-1:0];
        CFG_PAINT_EN:     paint_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (fw_r == '0) ? DIM_W'(1) : ((fw_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_r);
    h_eff = (fh_r == '0) ? DIM_W'(1)
                         : ((fh_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    fin       = 1'b0;
    ctl       = '0;
    we        = 1'b0;
    waddr     = addr_r;
    wdata     = merged;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        accept      = in_tvalid;
        ctl.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        we        = 1'b1;
        ctl.merge = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        ctl.add   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        fin = room;
        if (room) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= ADDR_W'({ {ADDR_W{1'b0}}, row } * MAX_WIDTH + { {ADDR_W{1'b0}}, col });
    end
  end

  fdmd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (accept),
    .raddr (ADDR_W'({ {ADDR_W{1'b0}}, row } * MAX_WIDTH + { {ADDR_W{1'b0}}, col })),
    .rdata (rdata)
  );

  fdmd_act u_act (
    .clk   (clk),
    .ctl   (ctl),
    .pix   (in_tdata),
    .slot  (slot),
    .rdata (rdata),
    .wdata (merged),
    .act   (act)
  );

  fdmd_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin        (fin),
    .act        (act),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .detect_thr (det_thr_r),
    .paint_thr  (paint_thr_r),
    .paint_en   (paint_en_r),
    .col        (col),
    .row        (row),
    .slot       (slot),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### hw/rtl/fdmd_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             ren,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fdmd_act.sv
// Activity datapath: gray conversion, slot merge, adjacent slot differences,
// sum, times three, and divide by the frame count. Depends on fdmd_pkg.
`default_nettype none
module fdmd_act (
  input  wire logic                           clk,
  input  wire fdmd_pkg::act_ctl_t             ctl,
  input  wire logic [fdmd_pkg::IN_DATA_W-1:0] pix,
  input  wire logic [fdmd_pkg::SLOT_W-1:0]    slot,
  input  wire logic [fdmd_pkg::ROW_W-1:0]     rdata,
  output logic      [fdmd_pkg::ROW_W-1:0]     wdata,
  output logic      [fdmd_pkg::ACT_W-1:0]     act
);
  import fdmd_pkg::*;

  logic [PIX_W-1:0]  gray_r;
  logic [SLOT_W-1:0] slot_r;
  logic [PIX_W-1:0]  lane [FRAMES];
  logic [PIX_W-1:0]  diff_nxt [FRAMES-1];
  logic [PIX_W-1:0]  diff_r [FRAMES-1];
  logic [SUM3_W-1:0] sum3_nxt, sum3_r;
  logic [PROD_W-1:0] prod_nxt, prod_r;
  logic [SUM_W-1:0]  acc;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      lane[i] = (slot_r == SLOT_W'(i)) ? gray_r : rdata[i*PIX_W +: PIX_W];
      wdata[i*PIX_W +: PIX_W] = lane[i];
    end
    for (int i = 1; i < FRAMES; i++) begin
      diff_nxt[i-1] = (lane[i] > lane[i-1]) ? (lane[i] - lane[i-1])
                                             : (lane[i-1] - lane[i]);
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < FRAMES - 1; i++) begin
      acc = acc + SUM_W'(diff_r[i]);
    end
    sum3_nxt = (SUM3_W'(acc) << 1) + SUM3_W'(acc);
    prod_nxt = PROD_W'(sum3_r) * PROD_W'(RECIP);
  end

  assign act = ACT_W'(prod_r >> DIV_S);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      gray_r <= div3(pix[7:0]) + div3(pix[15:8]) + div3(pix[23:16]);
      slot_r <= slot;
    end
    if (ctl.merge) begin
      diff_r <= diff_nxt;
    end
    if (ctl.add) begin
      sum3_r <= sum3_nxt;
    end
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fdmd_track.sv
// Raster counters, write slot, motion bounding box and the result register.
// Depends on fdmd_pkg.
`default_nettype none
module fdmd_track (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            fin,
  input  wire logic [fdmd_pkg::ACT_W-1:0]      act,
  input  wire logic [fdmd_pkg::DIM_W-1:0]      w_eff,
  input  wire logic [fdmd_pkg::DIM_W-1:0]      h_eff,
  input  wire logic [fdmd_pkg::THR_W-1:0]      detect_thr,
  input  wire logic [fdmd_pkg::THR_W-1:0]      paint_thr,
  input  wire logic                            paint_en,
  output logic      [fdmd_pkg::X_W-1:0]        col,
  output logic      [fdmd_pkg::Y_W-1:0]        row,
  output logic      [fdmd_pkg::SLOT_W-1:0]     slot,
  output logic                                 room,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [fdmd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tlast
);
  import fdmd_pkg::*;

  logic [X_W-1:0]    col_r, col_nxt;
  logic [Y_W-1:0]    row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [DIM_W-1:0]  min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic [X_W-1:0]    max_x_r, max_x_nxt;
  logic [Y_W-1:0]    max_y_r, max_y_nxt;
  logic              any_r, any_nxt;
  logic              valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic              last_r;
  logic              first, detect, paint, last_col, last;
  logic [DIM_W-1:0]  bminx, bminy;
  logic [X_W-1:0]    bmaxx;
  logic [Y_W-1:0]    bmaxy;
  logic              bany;

  always_comb begin
    first  = (col_r == '0) && (row_r == '0);
    bminx  = first ? w_eff : min_x_r;
    bminy  = first ? h_eff : min_y_r;
    bmaxx  = first ? '0 : max_x_r;
    bmaxy  = first ? '0 : max_y_r;
    bany   = first ? 1'b0 : any_r;
    detect = act > detect_thr;
    paint  = paint_en && (act > paint_thr);

    min_x_nxt = bminx;
    min_y_nxt = bminy;
    max_x_nxt = bmaxx;
    max_y_nxt = bmaxy;
    any_nxt   = bany;
    if (detect) begin
      if ({1'b0, col_r} < bminx) min_x_nxt = {1'b0, col_r};
      if ({1'b0, row_r} < bminy) min_y_nxt = {1'b0, row_r};
      if (col_r > bmaxx) max_x_nxt = col_r;
      if (row_r > bmaxy) max_y_nxt = row_r;
      any_nxt = 1'b1;
    end

    last_col = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
    last     = last_col && (({1'b0, row_r} + DIM_W'(1)) >= h_eff);

    col_nxt  = col_r + X_W'(1);
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (last) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = (slot_r == SLOT_W'(FRAMES - 1)) ? '0 : slot_r + SLOT_W'(1);
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = row_r + Y_W'(1);
    end

    data_nxt        = '0;
    data_nxt[9:0]   = act;
    data_nxt[10]    = paint;
    data_nxt[11]    = detect;
    data_nxt[19:12] = col_r;
    data_nxt[27:20] = row_r;
    if (last) begin
      data_nxt[28]    = any_nxt;
      data_nxt[37:29] = min_x_nxt;
      data_nxt[45:38] = max_x_nxt;
      data_nxt[54:46] = min_y_nxt;
      data_nxt[62:55] = max_y_nxt;
    end

    room      = !valid_r || out_tready;
    valid_nxt = fin ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      min_x_r <= DIM_W'(MAX_WIDTH);
      min_y_r <= DIM_W'(MAX_HEIGHT);
      max_x_r <= '0;
      max_y_r <= '0;
      any_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (fin) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        slot_r  <= slot_nxt;
        min_x_r <= min_x_nxt;
        min_y_r <= min_y_nxt;
        max_x_r <= max_x_nxt;
        max_y_r <= max_y_nxt;
        any_r   <= any_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      data_r <= data_nxt;
      last_r <= last;
    end
  end

  assign col        = col_r;
  assign row        = row_r;
  assign slot       = slot_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### tb/sv/tb_frame_difference_motion_detector.sv
// Self-checking testbench for frame_difference_motion_detector: pixel streams at several
// frame sizes and thresholds, checked field by field against a behavioral model kept here.
// Depends on fdmd_pkg and the block's RTL; needs no files or arguments.
module tb_frame_difference_motion_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import fdmd_pkg::*;

  localparam int PIXEL_CYCLES = 5;
  localparam int SETTLE_CYCLES = 2 * PIXEL_CYCLES;
  localparam int TAIL_CYCLES = 4 * PIXEL_CYCLES;
  // clearing pass after reset writes every row of the store with no pixel accepted
  localparam int QUIET_LIMIT = 4 * DEPTH;
  localparam int DIR_ROWS = 24;
  localparam int PHASES = 14;
  localparam int SMALL_ITEMS = 70;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic       done;
    logic       spare;
    logic [7:0] max_y;
    logic [8:0] min_y;
    logic [7:0] max_x;
    logic [8:0] min_x;
    logic       motion;
    logic [7:0] y;
    logic [7:0] x;
    logic       detect;
    logic       paint;
    logic [9:0] act;
  } motion_report_t;

  typedef struct {
    bit setup;
    int r, g, b;
    int act;
    int w, h, dt, pt, pe;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_difference_motion_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // model state
  bit [7:0] gray_frames [FRAMES*MAX_HEIGHT*MAX_WIDTH];
  int slot_now = 0, col_now = 0, row_now = 0;
  int box_x_lo = MAX_WIDTH, box_x_hi = 0, box_y_lo = MAX_HEIGHT, box_y_hi = 0;
  bit motion_seen = 1'b0;
  int width_reg = 256, height_reg = 256, detect_thr = 0, paint_thr = 0;
  bit paint_on = 1'b0;

  motion_report_t pending_reports[$];
  int idle_pct = 0, stall_pct = 0;
  int mismatches = 0, results_seen = 0, pixels_sent = 0, frames_seen = 0;
  int detects_seen = 0, setups_done = 0, quiet_cycles = 0;

  string field_name [12] = '{"activity", "paint_mark", "detect_mark", "pixel_x", "pixel_y",
                             "motion_found", "box_min_x", "box_max_x", "box_min_y",
                             "box_max_y", "spare_bit", "frame_done"};
  int field_lsb [12] = '{0, 10, 11, 12, 20, 28, 29, 38, 46, 55, 63, 64};
  int field_width [12] = '{10, 1, 1, 8, 8, 1, 9, 8, 9, 8, 1, 1};

  // rows 0-6: typed results for fresh positions in slot 0, thresholds at reset
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0,   0,   0,   0,   0, 0, 0,   0,    0, 0},
    '{1'b0, 255, 255, 255, 191, 0, 0,   0,    0, 0},
    '{1'b0, 255,   0,   0,  63, 0, 0,   0,    0, 0},
    '{1'b0,   0, 255,   0,  63, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0, 255,  63, 0, 0,   0,    0, 0},
    '{1'b0,   2,   2,   2,   0, 0, 0,   0,    0, 0},
    '{1'b0,   5,   5,   5,   2, 0, 0,   0,    0, 0},
    '{1'b1,   0,   0,   0,  -1, 0, 2,   0,    0, 1},
    '{1'b0,  10,  20,  30,  -1, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b1,   0,   0,   0,  -1, 3, 2, 765, 1023, 1},
    '{1'b0, 255, 255, 255,  -1, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b0, 255, 255, 255,  -1, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b0, 255, 255, 255,  -1, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b1,   0,   0,   0,  -1, 3, 2,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b0, 255, 255, 255,  -1, 0, 0,   0,    0, 0},
    '{1'b0,   0,   0,   0,  -1, 0, 0,   0,    0, 0},
    '{1'b0, 128,  64,  32,  -1, 0, 0,   0,    0, 0},
    '{1'b0,  77, 200,  13,  -1, 0, 0,   0,    0, 0},
    '{1'b0, 255, 255, 255,  -1, 0, 0,   0,    0, 0}
  };

  function automatic int clamp_dim(input int v, input int maxv);
    return (v < 1) ? 1 : (v > maxv) ? maxv : v;
  endfunction

  function automatic motion_report_t predict_activity(input int r, input int g, input int b);
    motion_report_t rep;
    int w, h, gray, sum, a, c, act;
    bit last_col, last;
    rep = '0;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (col_now == 0 && row_now == 0) begin
      box_x_lo = w;
      box_x_hi = 0;
      box_y_lo = h;
      box_y_hi = 0;
      motion_seen = 1'b0;
    end
    gray = r / 3 + g / 3 + b / 3;
    gray_frames[(slot_now * MAX_HEIGHT + row_now) * MAX_WIDTH + col_now] = gray[7:0];
    sum = 0;
    // slot order, not arrival order
    for (int i = 1; i < FRAMES; i++) begin
      a = gray_frames[(i * MAX_HEIGHT + row_now) * MAX_WIDTH + col_now];
      c = gray_frames[((i - 1) * MAX_HEIGHT + row_now) * MAX_WIDTH + col_now];
      sum += (a > c) ? a - c : c - a;
    end
    act = 3 * sum / FRAMES;
    rep.act = 10'(act);
    rep.detect = act > detect_thr;
    rep.paint = paint_on && act > paint_thr;
    rep.x = 8'(col_now);
    rep.y = 8'(row_now);
    if (rep.detect) begin
      if (col_now > box_x_hi) box_x_hi = col_now;
      if (col_now < box_x_lo) box_x_lo = col_now;
      if (row_now > box_y_hi) box_y_hi = row_now;
      if (row_now < box_y_lo) box_y_lo = row_now;
      motion_seen = 1'b1;
    end
    last_col = col_now + 1 >= w;
    last = last_col && row_now + 1 >= h;
    if (last) begin
      rep.done = 1'b1;
      rep.motion = motion_seen;
      rep.min_x = 9'(box_x_lo);
      rep.max_x = 8'(box_x_hi);
      rep.min_y = 9'(box_y_lo);
      rep.max_y = 8'(box_y_hi);
      slot_now = (slot_now + 1) % FRAMES;
      col_now = 0;
      row_now = 0;
    end else if (last_col) begin
      col_now = 0;
      row_now = row_now + 1;
    end else begin
      col_now = col_now + 1;
    end
    return rep;
  endfunction

  task automatic flag_mismatch(input string what, input logic [64:0] got,
                               input logic [64:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %s on result %0d: got %0h, expected %0h", what, results_seen, got,
               want);
  endtask

  task automatic send_pixel(input int r, input int g, input int b, input int typed_act);
    motion_report_t rep;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {8'(b), 8'(g), 8'(r)};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    rep = predict_activity(r, g, b);
    if (typed_act >= 0) begin
      rep.act = 10'(typed_act);
      rep.detect = typed_act > 0;
    end
    pending_reports.push_back(rep);
    pixels_sent++;
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = val & 'h1FF;
      CFG_FRAME_HEIGHT: height_reg = val & 'h1FF;
      CFG_DETECT_THR:   detect_thr = val & 'h3FF;
      CFG_PAINT_THR:    paint_thr = val & 'h3FF;
      CFG_PAINT_EN:     paint_on = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int w, input int h, input int dt, input int pt,
                                input int pe);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_DETECT_THR, dt);
    write_reg(CFG_PAINT_THR, pt);
    write_reg(CFG_PAINT_EN, pe);
    cfg_valid <= 1'b0;
    setups_done++;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 765;
      2: return $urandom_range(0, 1023);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin : check_results
    motion_report_t want;
    logic [64:0] got_v, want_v, got_f, want_f;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_v = {out_tlast, out_tdata};
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no pending request", got_v, '0);
      end else begin
        want = pending_reports.pop_front();
        want_v = want;
        if (want.done) frames_seen++;
        if (want.detect) detects_seen++;
        for (int k = 0; k < 12; k++) begin
          got_f = (got_v >> field_lsb[k]) & ((65'd1 << field_width[k]) - 65'd1);
          want_f = (want_v >> field_lsb[k]) & ((65'd1 << field_width[k]) - 65'd1);
          if (got_f !== want_f) flag_mismatch(field_name[k], got_f, want_f);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               pending_reports.size());
      $display("tb_frame_difference_motion_detector failed");
      $finish;
    end
  end

  initial begin : stimulus
    int w_val, h_val, count, mode, base_px, choice;
    int r, g, b;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIR_ROWS; n++) begin
      if (dir_tab[n].setup) begin
        drain_results();
        apply_settings(dir_tab[n].w, dir_tab[n].h, dir_tab[n].dt, dir_tab[n].pt,
                       dir_tab[n].pe);
      end else begin
        send_pixel(dir_tab[n].r, dir_tab[n].g, dir_tab[n].b, dir_tab[n].act);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      mode = p % 4;
      idle_pct = (mode == 1) ? 85 : (mode == 3) ? 27 : 0;
      stall_pct = (mode == 2) ? 85 : (mode == 3) ? 27 : 0;
      // two phases run a full-width and a full-height frame; the width is clamped from an oversize value
      if (p == 2) begin
        w_val = 511;
        h_val = 1;
      end else if (p == 5) begin
        w_val = 1;
        h_val = 256;
      end else begin
        w_val = $urandom_range(0, 8);
        h_val = $urandom_range(0, 6);
      end
      if (p == 2 || p == 5)
        count = clamp_dim(w_val, MAX_WIDTH) * clamp_dim(h_val, MAX_HEIGHT) + 8;
      else
        count = SMALL_ITEMS;
      apply_settings(w_val, h_val, pick_threshold(), pick_threshold(), $urandom_range(0, 1));
      base_px = $urandom_range(0, 'hFFFFFF);
      for (int i = 0; i < count; i++) begin
        choice = $urandom_range(0, 9);
        if (choice < 4) begin
          r = base_px & 'hFF;
          g = (base_px >> 8) & 'hFF;
          b = (base_px >> 16) & 'hFF;
        end else if (choice < 8) begin
          r = $urandom_range(0, 255);
          g = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end else begin
          r = $urandom_range(0, 1) * 255;
          g = $urandom_range(0, 1) * 255;
          b = $urandom_range(0, 1) * 255;
        end
        send_pixel(r, g, b, -1);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d pixels under %0d register setups; %0d frame ends, %0d pixels above",
             pixels_sent, setups_done, frames_seen, detects_seen);
    $display("the detect threshold, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb_frame_difference_motion_detector passed");
    end else begin
      $display("tb_frame_difference_motion_detector failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fdmd_pkg.sv
hw/rtl/fdmd_ram.sv
hw/rtl/fdmd_act.sv
hw/rtl/fdmd_track.sv
hw/rtl/frame_difference_motion_detector.sv
tb/sv/tb_frame_difference_motion_detector.sv
